@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers shared by the search block's modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every rising edge outside reset.
`define STBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define STBS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define STBS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/stbs_pkg.sv @@
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared constants, command codes and controller/datapath types.
// ----------------------------------------------------------------------------
package stbs_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int CFG_W       = 5;
  localparam int SLOT_W      = 4;
  localparam int POS_W       = 4;
  localparam int DATA_W      = 32;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_DELIVER
  } stbs_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_wr;   // write the table slot
    logic start;     // set up bounds and key
    logic step;      // narrow the bounds
    logic hold_res;  // park the result
    logic out_live;  // load output from the current probe
    logic out_held;  // load output from the parked result
  } stbs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic done;
  } stbs_stat_t;

endpackage

@@ hw/rtl/stbs_dp.sv @@
// ----------------------------------------------------------------------------
// stbs_dp
// Table storage, count register, search bounds, probe compare, result regs.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stbs_dp
  import stbs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic [SLOT_W-1:0]        in_slot,
  input  logic signed [DATA_W-1:0] in_value,
  input  stbs_cmd_t                cmd,
  output stbs_stat_t               stat,
  output logic                     out_found,
  output logic [POS_W-1:0]         out_position
);

  logic signed [DATA_W-1:0] entry_r [TABLE_DEPTH];
  logic [CFG_W-1:0]         entry_count_r;
  logic [CNT_W-1:0]         lo_r, lo_nxt;
  logic [CNT_W-1:0]         hix_r, hix_nxt;
  logic signed [DATA_W-1:0] key_r;
  logic                     held_found_r;
  logic [POS_W-1:0]         held_pos_r;
  logic                     out_found_r;
  logic [POS_W-1:0]         out_position_r;

  logic [CNT_W-1:0]         cnt_sat;
  logic [CNT_W:0]           mid_sum;
  logic [IDX_W-1:0]         mid;
  logic [CNT_W-1:0]         mid_ext;
  logic signed [DATA_W-1:0] probe_entry;
  logic                     empty, key_lt, key_gt, key_eq, nxt_empty;
  logic                     res_found;
  logic [POS_W-1:0]         res_pos;
  logic                     slot_ok;

  // Saturate the count to the table depth
  assign cnt_sat = (32'(entry_count_r) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                           : CNT_W'(entry_count_r);

  // Range is [lo, hix); midpoint floor((lo + hix - 1) / 2)
  assign empty       = (lo_r >= hix_r);
  assign mid_sum     = {1'b0, lo_r} + {1'b0, hix_r} - (CNT_W+1)'(1);
  assign mid         = mid_sum[IDX_W:1];
  assign mid_ext     = {1'b0, mid};
  assign probe_entry = entry_r[mid];
  assign key_lt      = (key_r < probe_entry);
  assign key_gt      = (key_r > probe_entry);
  assign key_eq      = (key_r == probe_entry);

  always_comb begin
    lo_nxt  = lo_r;
    hix_nxt = hix_r;
    if (key_gt) begin
      lo_nxt = mid_ext + CNT_W'(1);
    end
    if (key_lt) begin
      hix_nxt = mid_ext;
    end
  end

  assign nxt_empty = (lo_nxt >= hix_nxt);
  assign stat.done = empty || key_eq || nxt_empty;
  assign res_found = !empty && key_eq;
  assign res_pos   = res_found ? POS_W'(mid) : '0;

  assign slot_ok = (32'(in_slot) < 32'(TABLE_DEPTH));

  // Table storage, no reset
  always_ff @(posedge clk) begin
    if (cmd.load_wr && slot_ok) begin
      entry_r[IDX_W'(in_slot)] <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
      lo_r          <= '0;
      hix_r         <= '0;
    end else begin
      if (cfg_we) begin
        entry_count_r <= cfg_wdata;
      end
      if (cmd.start) begin
        lo_r  <= '0;
        hix_r <= cnt_sat;
      end else if (cmd.step) begin
        lo_r  <= lo_nxt;
        hix_r <= hix_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key_r <= in_value;
    end
    if (cmd.hold_res) begin
      held_found_r <= res_found;
      held_pos_r   <= res_pos;
    end
    if (cmd.out_live) begin
      out_found_r    <= res_found;
      out_position_r <= res_pos;
    end else if (cmd.out_held) begin
      out_found_r    <= held_found_r;
      out_position_r <= held_pos_r;
    end
  end

  assign out_found    = out_found_r;
  assign out_position = out_position_r;

  `STBS_ASSERT(a_bounds_ordered, lo_r <= hix_r, "search bounds crossed")
  `STBS_ASSERT(a_hix_in_range, hix_r <= CNT_W'(TABLE_DEPTH), "upper bound past depth")
  `STBS_ASSERT_NXT(a_start_bounds, cmd.start, lo_r == '0, "lower bound not cleared")

endmodule

@@ hw/rtl/stbs_ctrl.sv @@
// ----------------------------------------------------------------------------
// stbs_ctrl
// Sequencer for loads, probe iterations and result hand-off.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stbs_ctrl
  import stbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_cmd,
  output logic       in_ready,
  input  logic       out_ready,
  output logic       out_valid,
  input  stbs_stat_t stat,
  output stbs_cmd_t  cmd
);

  stbs_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        in_acc, out_free;
  logic        search_acc;
  logic [4:0]  cmd_bits;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_cmd == CMD_SEARCH)) begin
          state_nxt = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (stat.done) begin
          state_nxt = out_free ? ST_IDLE : ST_DELIVER;
        end
      end
      ST_DELIVER: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.load_wr = in_acc && (in_cmd == CMD_LOAD);
        cmd.start   = in_acc && (in_cmd == CMD_SEARCH);
      end
      ST_PROBE: begin
        if (stat.done) begin
          cmd.out_live = out_free;
          cmd.hold_res = !out_free;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_DELIVER: begin
        cmd.out_held = out_free;
      end
      default: cmd = '0;
    endcase
  end

  always_comb begin
    if (cmd.out_live || cmd.out_held) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  assign search_acc = in_acc && (in_cmd == CMD_SEARCH);
  assign cmd_bits   = {cmd.load_wr, cmd.start, cmd.step, cmd.out_live, cmd.out_held};

  `STBS_ASSERT_NXT(a_search_starts, search_acc, state_r == ST_PROBE, "search not started")
  `STBS_ASSERT_IMP(a_deliver_blocked, state_r == ST_DELIVER, out_valid_r, "no output held")
  `STBS_ASSERT(a_cmd_exclusive, $onehot0(cmd_bits), "overlapping commands")

endmodule

@@ hw/rtl/sorted_table_binary_search.sv @@
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// Sorted table of signed words with slot loads and binary-search lookups.
// ----------------------------------------------------------------------------
//
//   channel  | ports                                  | beat carries
//   ---------+----------------------------------------+--------------------------
//   in       | in_valid/in_ready, cmd, slot, value    | load (cmd 0) or search (1)
//   out      | out_valid/out_ready, found, position   | one beat per search only
//   cfg      | cfg_we, cfg_wdata                      | entry_count, no wait state
//
// A load beat is accepted back to back. A search beat is accepted, then the
// probe loop runs (at most log2(depth)+1 probes, five over 16 entries); an
// empty range ends on its first probe. The probe loop reads the table by
// the midpoint and compares once per cycle. A finished result sits in the
// output register while the next beat is accepted; if that register is
// still full at the end of a search, the result is parked and in_ready
// stays low until it moves out.
// Reset clears the controller, the count and the bounds; table contents are
// undefined until loaded.
// ----------------------------------------------------------------------------
module sorted_table_binary_search
  import stbs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  // configuration
  input  logic                     cfg_we,
  input  logic [CFG_W-1:0]         cfg_wdata,
  // input beats
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_cmd,
  input  logic [SLOT_W-1:0]        in_slot,
  input  logic signed [DATA_W-1:0] in_value,
  // result beats
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_found,
  output logic [POS_W-1:0]         out_position
);

  stbs_cmd_t  dp_cmd;
  stbs_stat_t dp_stat;

  // Sequencer: accepts beats, steps the probe loop, hands off results
  stbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_cmd),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  // Table, bounds, compare and output register
  stbs_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_slot      (in_slot),
    .in_value     (in_value),
    .cmd          (dp_cmd),
    .stat         (dp_stat),
    .out_found    (out_found),
    .out_position (out_position)
  );

endmodule

@@ dv/lookup_check_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lookup_check_pkg
// Shadow table and answer checker for the sorted-table search block.
// ----------------------------------------------------------------------------
package lookup_check_pkg;

  import stbs_pkg::*;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } lookup_answer_t;

  class lookup_checker;

    logic signed [DATA_W-1:0] shadow_table [TABLE_DEPTH];
    logic [CFG_W-1:0]         shadow_count;
    lookup_answer_t           expected_answers [$];
    int                       mismatches;

    function new();
      foreach (shadow_table[i]) shadow_table[i] = '0;
      shadow_count = '0;
      mismatches   = 0;
    endfunction

    function void set_count(input logic [CFG_W-1:0] count);
      shadow_count = count;
    endfunction

    function int pending();
      return expected_answers.size();
    endfunction

    // Follow the same probe sequence as the block: midpoint rounded down,
    // stop on the first equal entry, give up once the range is empty.
    function lookup_answer_t predict_lookup(input logic signed [DATA_W-1:0] key);
      int             lo;
      int             hi;
      int             mid;
      lookup_answer_t answer;
      answer = '0;
      lo     = 0;
      hi     = ((shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count)) - 1;
      while (lo <= hi) begin
        mid = (lo + hi) / 2;
        if (key < shadow_table[mid]) begin
          hi = mid - 1;
        end else if (key > shadow_table[mid]) begin
          lo = mid + 1;
        end else begin
          answer.found    = 1'b1;
          answer.position = mid[POS_W-1:0];
          hi              = lo - 1;
        end
      end
      return answer;
    endfunction

    function void note_beat(input logic cmd, input logic [SLOT_W-1:0] slot,
                            input logic signed [DATA_W-1:0] value);
      if (cmd == CMD_LOAD) begin
        shadow_table[slot] = value;
      end else begin
        expected_answers.push_back(predict_lookup(value));
      end
    endfunction

    function void check_answer(input logic found, input logic [POS_W-1:0] position);
      lookup_answer_t want;
      if (expected_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: found=%0d position=%0d", found, position);
      end else begin
        want = expected_answers.pop_front();
        if (found !== want.found || position !== want.position) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected found=%0d position=%0d, got found=%0d position=%0d",
                     want.found, want.position, found, position);
        end
      end
    endfunction

  endclass

endpackage

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives loads and searches into the sorted-table search block, changes the
// entry count between phases and checks every result beat against a shadow
// table kept by the scoreboard, under random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;

  import stbs_pkg::*;
  import lookup_check_pkg::*;

  localparam int                       SETTLE_CYCLES = 10;
  localparam int                       HOLD_OFF      = 300;
  localparam int                       PHASES        = 11;
  localparam int                       PHASE_BEATS   = 145;
  localparam longint                   WATCHDOG_NS   = 2_000_000;
  localparam logic [CFG_W-1:0]         COUNT_MAX     = {CFG_W{1'b1}};
  localparam logic signed [DATA_W-1:0] WORD_MIN      = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] WORD_MAX      = {1'b0, {(DATA_W-1){1'b1}}};

  logic                     clk;
  logic                     rst_n        = 1'b0;
  logic                     cfg_we       = 1'b0;
  logic [CFG_W-1:0]         cfg_wdata    = '0;
  logic                     in_valid     = 1'b0;
  logic                     in_ready;
  logic                     in_cmd       = CMD_LOAD;
  logic [SLOT_W-1:0]        in_slot      = '0;
  logic signed [DATA_W-1:0] in_value     = '0;
  logic                     out_valid;
  logic                     out_ready    = 1'b0;
  logic                     out_found;
  logic [POS_W-1:0]         out_position;

  // Driver-side image of what has been loaded, used only to pick keys that hit or sit beside an entry.
  logic signed [DATA_W-1:0] loaded_values [TABLE_DEPTH];

  // calm switches off idling on both channels; hold_cycles asks the receiver
  // for a counted hold-off.
  bit                       calm        = 1'b0;
  int                       hold_cycles = 0;

  lookup_checker book = new();

  sorted_table_binary_search dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_slot      (in_slot),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_found    (out_found),
    .out_position (out_position)
  );

  initial begin : clock_gen
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Give up after a generous fixed time; a correct run ends far sooner.
  initial begin : watchdog
    #(WATCHDOG_NS);
    $display("TEST FAILED");
    $finish;
  end

  // Receiver: count down a requested hold-off, otherwise stall about one
  // cycle in three unless the calm stretch is on.
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 33);
      end
    end
  end

  // Monitor both channels on the edge that moves a beat. Values seen here are
  // the ones present just before the edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) book.note_beat(in_cmd, in_slot, in_value);
      if (out_valid && out_ready) book.check_answer(out_found, out_position);
    end
  end

  // Offer one beat, idling first at random, and hold it until it is taken.
  task automatic send_beat(input logic cmd, input logic [SLOT_W-1:0] slot,
                           input logic signed [DATA_W-1:0] value);
    if (!calm) begin
      while ($urandom_range(99) < 33) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_slot  <= slot;
    in_value <= value;
    if (cmd == CMD_LOAD) loaded_values[slot] = value;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid, wait for every pending answer, then let a trailing load or
  // search settle inside the block.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (book.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only ever called with the block idle.
  task automatic write_count(input logic [CFG_W-1:0] count);
    cfg_we    <= 1'b1;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_we    <= 1'b0;
    book.set_count(count);
  endtask

  // One phase: set the count, then repeatedly load a freshly sorted table and
  // search it, mostly with keys that are present or sit right beside an entry,
  // and now and then with a stray load that breaks the ordering.
  task automatic run_phase(input logic [CFG_W-1:0] count, input int beats,
                           input bit quiet, input int hold_off);
    int                       sent;
    int                       span;
    int                       roll;
    int                       base;
    int                       s;
    int                       floor_val;
    int                       ladder [$];
    logic signed [DATA_W-1:0] key;
    wait_idle();
    write_count(count);
    calm        = quiet;
    hold_cycles = hold_off;
    span        = (count > TABLE_DEPTH) ? TABLE_DEPTH : int'(count);
    sent        = 0;
    while (sent < beats) begin
      ladder.delete();
      case ($urandom_range(2))
        0: begin
          repeat (TABLE_DEPTH) ladder.push_back($urandom());
        end
        1: begin
          // narrow window: close neighbours and some duplicates
          floor_val = $urandom();
          repeat (TABLE_DEPTH) ladder.push_back(floor_val + $urandom_range(2 * TABLE_DEPTH));
        end
        default: begin
          // tiny window: long runs of equal entries
          repeat (TABLE_DEPTH) ladder.push_back(int'($urandom_range(6)) - 3);
        end
      endcase
      ladder.sort();
      base = $urandom_range(TABLE_DEPTH - 1);
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        s = (base + i) % TABLE_DEPTH;
        send_beat(CMD_LOAD, s[SLOT_W-1:0], ladder[s]);
        sent++;
      end
      repeat ($urandom_range(12, 28)) begin
        roll = $urandom_range(99);
        if (roll < 8) begin
          send_beat(CMD_LOAD, SLOT_W'($urandom_range(TABLE_DEPTH - 1)), $urandom());
        end else begin
          if (span > 0 && roll < 60) begin
            key = loaded_values[$urandom_range(span - 1)];
          end else if (span > 0 && roll < 75) begin
            key = loaded_values[$urandom_range(span - 1)] + ($urandom_range(1) ? 1 : -1);
          end else if (roll < 85) begin
            case ($urandom_range(2))
              0:       key = WORD_MIN;
              1:       key = WORD_MAX;
              default: key = '0;
            endcase
          end else begin
            key = $urandom();
          end
          send_beat(CMD_SEARCH, SLOT_W'($urandom_range(TABLE_DEPTH - 1)), key);
        end
        sent++;
      end
    end
    calm = 1'b0;
  endtask

  initial begin : stimulus
    logic signed [DATA_W-1:0] ladder [TABLE_DEPTH];
    logic [CFG_W-1:0]         counts [PHASES];
    ladder = '{WORD_MIN, -100000, -50, -3, 0, 5, 5, 5,
               12, 99, 1000, 4096, 65535, 1048576, 32'sh4000_0000, WORD_MAX};
    counts = '{5'd16, 5'd1, 5'd0, 5'd2, COUNT_MAX, 5'd15,
               5'd17, 5'd3, 5'd8, 5'd16, 5'd0};
    counts[PHASES-1] = CFG_W'($urandom_range(COUNT_MAX));

    // Hold reset, then release it.
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: full sorted table spanning both word extremes, with a run
    // of three equal entries in the middle.
    write_count(CFG_W'(TABLE_DEPTH));
    for (int i = 0; i < TABLE_DEPTH; i++) send_beat(CMD_LOAD, SLOT_W'(i), ladder[i]);
    send_beat(CMD_SEARCH, 4'h0, WORD_MIN);           // lowest entry
    send_beat(CMD_SEARCH, 4'hF, WORD_MAX);           // highest entry
    send_beat(CMD_SEARCH, 4'h3, 5);                  // duplicate run, first probe hit
    send_beat(CMD_SEARCH, 4'h0, 6);                  // falls in a gap
    send_beat(CMD_SEARCH, 4'hA, WORD_MIN + 1);       // just above the bottom
    send_beat(CMD_SEARCH, 4'h5, 0);                  // slot field is ignored
    send_beat(CMD_LOAD,   4'h8, -999);               // break the ordering
    send_beat(CMD_SEARCH, 4'h0, 1000);               // the bad entry lies off the probe path

    // Empty table, then a count above the depth.
    wait_idle();
    write_count('0);
    send_beat(CMD_SEARCH, 4'h0, 0);
    wait_idle();
    write_count(COUNT_MAX);
    send_beat(CMD_SEARCH, 4'h0, WORD_MAX);

    // Random phases: one with no idling at all, one with a long receiver
    // hold-off so the block parks a result and stalls its input.
    for (int p = 0; p < PHASES; p++)
      run_phase(counts[p], PHASE_BEATS, p == 4, (p == 5) ? HOLD_OFF : 0);

    // Drain and settle, then report.
    wait_idle();
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/stbs_pkg.sv
hw/rtl/stbs_dp.sv
hw/rtl/stbs_ctrl.sv
hw/rtl/sorted_table_binary_search.sv
dv/lookup_check_pkg.sv
dv/testbench.sv
